### design/mcp_pkg.sv
// shared codes and helper functions for the mqtt connect parser
`default_nettype none

package mcp_pkg;

    typedef logic [3:0] field_t;
    typedef logic [2:0] mal_t;
    typedef logic [1:0] rc_t;

    // field tags carried on field_id
    localparam field_t FLD_NAME_LEN   = 4'd0;
    localparam field_t FLD_NAME       = 4'd1;
    localparam field_t FLD_LEVEL      = 4'd2;
    localparam field_t FLD_FLAGS      = 4'd3;
    localparam field_t FLD_KEEPALIVE  = 4'd4;
    localparam field_t FLD_ID_LEN     = 4'd5;
    localparam field_t FLD_ID         = 4'd6;
    localparam field_t FLD_WTOPIC_LEN = 4'd7;
    localparam field_t FLD_WTOPIC     = 4'd8;
    localparam field_t FLD_WMSG_LEN   = 4'd9;
    localparam field_t FLD_WMSG       = 4'd10;
    localparam field_t FLD_USER_LEN   = 4'd11;
    localparam field_t FLD_USER       = 4'd12;
    localparam field_t FLD_PASS_LEN   = 4'd13;
    localparam field_t FLD_PASS       = 4'd14;
    localparam field_t FLD_DISCARD    = 4'd15;

    // malformed codes
    localparam mal_t MAL_NONE      = 3'd0;
    localparam mal_t MAL_RESERVED  = 3'd1;
    localparam mal_t MAL_WILL_RULE = 3'd2;
    localparam mal_t MAL_QOS3      = 3'd3;
    localparam mal_t MAL_LENGTH    = 3'd4;

    // connect return codes
    localparam rc_t RC_ACCEPTED   = 2'd0;
    localparam rc_t RC_BAD_LEVEL  = 2'd1;
    localparam rc_t RC_ID_REJECT  = 2'd2;
    localparam rc_t RC_BAD_CREDS  = 2'd3;

    // configuration register indexes
    localparam logic CFG_EXPECTED_LEVEL = 1'b0;
    localparam logic CFG_MAX_ID_LEN     = 1'b1;

    localparam logic [7:0]  RESET_EXPECTED_LEVEL = 8'd4;
    localparam logic [15:0] RESET_MAX_ID_LEN     = 16'd23;

    // connect flag bit positions
    localparam int FLAG_RESERVED = 0;
    localparam int FLAG_CLEAN    = 1;
    localparam int FLAG_WILL     = 2;
    localparam int FLAG_RETAIN   = 5;
    localparam int FLAG_PASS     = 6;
    localparam int FLAG_USER     = 7;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    // field that follows data field f under the received flags
    function automatic field_t next_field(input field_t f, input logic [7:0] fl);
        field_t nf;
        nf = FLD_DISCARD;
        if (f == FLD_NAME) nf = FLD_LEVEL;
        else if (f == FLD_ID && fl[FLAG_WILL]) nf = FLD_WTOPIC_LEN;
        else if (f == FLD_WTOPIC) nf = FLD_WMSG_LEN;
        else if (f <= FLD_WMSG && fl[FLAG_USER]) nf = FLD_USER_LEN;
        else if (f <= FLD_USER && fl[FLAG_PASS]) nf = FLD_PASS_LEN;
        return nf;
    endfunction

    function automatic mal_t flag_error(input logic [7:0] fl);
        mal_t e;
        e = MAL_NONE;
        if (fl[FLAG_RESERVED]) e = MAL_RESERVED;
        else if (!fl[FLAG_WILL] && (fl[FLAG_RETAIN:3] != 3'd0)) e = MAL_WILL_RULE;
        else if (fl[4:3] == 2'b11) e = MAL_QOS3;
        return e;
    endfunction

endpackage

`default_nettype wire

### design/mqtt_connect_parser.sv
// mqtt connect parser top level: byte tagging, flag checks and end-of-packet summary
`default_nettype none

// Streaming parser for the variable header and payload of an MQTT CONNECT
// packet, one byte per request. Each byte comes back tagged with its field
// (length prefixes, protocol name, level, flags, keep alive, client id, will
// topic and message, username, password, or discard) and a field end mark.
// The byte marked last also carries the packet summary: malformed code,
// connect return code, the assign-id hint and the received keep alive, level
// and flags; the parse state then rearms for the next packet. Throughput is
// one byte per clock while the receiver takes results: a byte passes the
// input register, then the field decode and state update that sit between
// that register and the result register, then the result register. Result
// register and input register are both refilled in the cycle a result is
// taken, so stalls on the output side cost no bubbles. Configuration writes
// take effect at once and should only be made while no packet is in flight.
module mqtt_connect_parser
    import mcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       field_id,
    output logic [7:0]       data_byte,
    output logic             field_end,
    output logic             done_res,
    output logic [2:0]       malformed,
    output logic [1:0]       return_code,
    output logic             assign_id,
    output logic [15:0]      keep_alive_out,
    output logic [7:0]       level_out,
    output logic [7:0]       flags_out
);

    // configuration
    logic [7:0]  expected_level_reg;
    logic [15:0] max_id_len_reg;

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // parse state
    field_t      field_pos_reg, field_pos_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        prefix_phase_reg, prefix_phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  level_reg, level_next;
    logic [15:0] keep_alive_reg, keep_alive_next;
    logic [15:0] id_length_reg, id_length_next;
    logic        id_bad_reg, id_bad_next;
    mal_t        error_reg, error_next;

    // result register
    logic        out_valid_reg;
    field_t      field_id_reg;
    logic [7:0]  data_byte_reg;
    logic        field_end_reg, field_end_next;
    logic        done_reg;
    mal_t        mal_reg, mal_next;
    rc_t         rc_reg, rc_next;
    logic        assign_reg, assign_next;
    logic [15:0] ka_out_reg, ka_out_next;
    logic [7:0]  lv_out_reg, lv_out_next;
    logic [7:0]  fl_out_reg, fl_out_next;

    logic        advance;
    logic [15:0] len_value;
    logic [15:0] bytes_dec;
    mal_t        fl_err;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_level_reg <= RESET_EXPECTED_LEVEL;
            max_id_len_reg     <= RESET_MAX_ID_LEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_LEVEL: expected_level_reg <= cfg_wdata[7:0];
                CFG_MAX_ID_LEN:     max_id_len_reg     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
            s1_last_reg <= last_byte;
        end
    end

    // field decode and state update
    always_comb
    begin
        field_pos_next    = field_pos_reg;
        len_hi_next       = len_hi_reg;
        bytes_left_next   = bytes_left_reg;
        prefix_phase_next = prefix_phase_reg;
        flags_next        = flags_reg;
        level_next        = level_reg;
        keep_alive_next   = keep_alive_reg;
        id_length_next    = id_length_reg;
        id_bad_next       = id_bad_reg;
        error_next        = error_reg;
        field_end_next    = 1'b0;
        mal_next          = MAL_NONE;
        rc_next           = RC_ACCEPTED;
        assign_next       = 1'b0;
        ka_out_next       = '0;
        lv_out_next       = '0;
        fl_out_next       = '0;
        len_value         = {len_hi_reg, s1_byte_reg};
        bytes_dec         = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : 16'd0;
        fl_err            = flag_error(s1_byte_reg);

        case (field_pos_reg)
            FLD_DISCARD:
            begin
                if (error_reg == MAL_NONE) error_next = MAL_LENGTH;
            end
            FLD_LEVEL:
            begin
                level_next     = s1_byte_reg;
                field_end_next = 1'b1;
                field_pos_next = FLD_FLAGS;
            end
            FLD_FLAGS:
            begin
                flags_next     = s1_byte_reg;
                field_end_next = 1'b1;
                if (fl_err != MAL_NONE)
                begin
                    error_next     = fl_err;
                    field_pos_next = FLD_DISCARD;
                end
                else
                    field_pos_next = FLD_KEEPALIVE;
            end
            FLD_NAME_LEN, FLD_KEEPALIVE, FLD_ID_LEN, FLD_WTOPIC_LEN,
            FLD_WMSG_LEN, FLD_USER_LEN, FLD_PASS_LEN:
            begin
                if (!prefix_phase_reg)
                begin
                    len_hi_next       = s1_byte_reg;
                    prefix_phase_next = 1'b1;
                end
                else
                begin
                    prefix_phase_next = 1'b0;
                    field_end_next    = 1'b1;
                    if (field_pos_reg == FLD_KEEPALIVE)
                    begin
                        keep_alive_next = len_value;
                        field_pos_next  = FLD_ID_LEN;
                    end
                    else
                    begin
                        bytes_left_next = len_value;
                        if (field_pos_reg == FLD_ID_LEN) id_length_next = len_value;
                        // an empty field skips its data bytes
                        if (len_value == 16'd0)
                            field_pos_next = next_field(field_pos_reg + 4'd1, flags_reg);
                        else
                            field_pos_next = field_pos_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                if (field_pos_reg == FLD_ID && !is_alnum(s1_byte_reg)) id_bad_next = 1'b1;
                bytes_left_next = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    field_end_next = 1'b1;
                    field_pos_next = next_field(field_pos_reg, flags_reg);
                end
            end
        endcase

        if (s1_last_reg)
        begin
            // truncated packet
            if (field_pos_next != FLD_DISCARD && error_next == MAL_NONE)
                error_next = MAL_LENGTH;
            mal_next    = error_next;
            ka_out_next = keep_alive_next;
            lv_out_next = level_next;
            fl_out_next = flags_next;
            if (error_next == MAL_NONE)
            begin
                if (level_next != expected_level_reg)
                    rc_next = RC_BAD_LEVEL;
                else if (id_length_next > max_id_len_reg || id_bad_next)
                    rc_next = RC_ID_REJECT;
                else if (id_length_next == 16'd0 && !flags_next[FLAG_CLEAN])
                    rc_next = RC_ID_REJECT;
                else
                begin
                    assign_next = (id_length_next == 16'd0);
                    if (flags_next[FLAG_PASS] && !flags_next[FLAG_USER])
                        rc_next = RC_BAD_CREDS;
                end
            end
            // rearm for the next packet
            field_pos_next    = FLD_NAME_LEN;
            len_hi_next       = '0;
            bytes_left_next   = '0;
            prefix_phase_next = 1'b0;
            flags_next        = '0;
            level_next        = '0;
            keep_alive_next   = '0;
            id_length_next    = '0;
            id_bad_next       = 1'b0;
            error_next        = MAL_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_pos_reg    <= FLD_NAME_LEN;
            len_hi_reg       <= '0;
            bytes_left_reg   <= '0;
            prefix_phase_reg <= 1'b0;
            flags_reg        <= '0;
            level_reg        <= '0;
            keep_alive_reg   <= '0;
            id_length_reg    <= '0;
            id_bad_reg       <= 1'b0;
            error_reg        <= MAL_NONE;
        end
        else if (advance)
        begin
            field_pos_reg    <= field_pos_next;
            len_hi_reg       <= len_hi_next;
            bytes_left_reg   <= bytes_left_next;
            prefix_phase_reg <= prefix_phase_next;
            flags_reg        <= flags_next;
            level_reg        <= level_next;
            keep_alive_reg   <= keep_alive_next;
            id_length_reg    <= id_length_next;
            id_bad_reg       <= id_bad_next;
            error_reg        <= error_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            field_id_reg  <= field_pos_reg;
            data_byte_reg <= s1_byte_reg;
            field_end_reg <= field_end_next;
            done_reg      <= s1_last_reg;
            mal_reg       <= mal_next;
            rc_reg        <= rc_next;
            assign_reg    <= assign_next;
            ka_out_reg    <= ka_out_next;
            lv_out_reg    <= lv_out_next;
            fl_out_reg    <= fl_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign field_id       = field_id_reg;
    assign data_byte      = data_byte_reg;
    assign field_end      = field_end_reg;
    assign done_res       = done_reg;
    assign malformed      = mal_reg;
    assign return_code    = rc_reg;
    assign assign_id      = assign_reg;
    assign keep_alive_out = ka_out_reg;
    assign level_out      = lv_out_reg;
    assign flags_out      = fl_out_reg;

    // summary fields stay zero on bytes that do not end a packet
    a_summary_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> mal_reg == MAL_NONE && rc_reg == RC_ACCEPTED
            && !assign_reg && ka_out_reg == 16'd0)
        else $error("summary fields set on a byte that does not end the packet");

    // a malformed packet carries no return code and no assign hint
    a_mal_no_rc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && mal_reg != MAL_NONE |-> rc_reg == RC_ACCEPTED && !assign_reg)
        else $error("return code reported for a malformed packet");

    // assign hint only on a well-formed packet end that is accepted or refused for bad credentials
    a_assign_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && assign_reg |-> done_reg && mal_reg == MAL_NONE
            && (rc_reg == RC_ACCEPTED || rc_reg == RC_BAD_CREDS))
        else $error("assign id hint on a rejected packet");

    // parse state rearms after the last byte
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last_reg |=> field_pos_reg == FLD_NAME_LEN && error_reg == MAL_NONE
            && !prefix_phase_reg && id_length_reg == 16'd0)
        else $error("parse state not cleared after end of packet");

endmodule

`default_nettype wire

### tb/sv/tb_mqtt_connect_parser.sv
// testbench for the mqtt connect parser: byte tagging, flag checks and packet summary
`timescale 1ns / 100ps

module tb_mqtt_connect_parser
    import mcp_pkg::*;
();

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 20;

    typedef enum logic { RX_ALWAYS, RX_PATTERN } rx_mode_t;

    typedef struct packed {
        field_t      field_id;
        logic [7:0]  data_byte;
        logic        field_end;
        logic        done;
        mal_t        mal;
        rc_t         rc;
        logic        assign_id;
        logic [15:0] ka;
        logic [7:0]  lvl;
        logic [7:0]  flg;
    } parsed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_EXPECTED_LEVEL;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  field_id;
    logic [7:0]  data_byte;
    logic        field_end;
    logic        done_res;
    logic [2:0]  malformed;
    logic [1:0]  return_code;
    logic        assign_id;
    logic [15:0] keep_alive_out;
    logic [7:0]  level_out;
    logic [7:0]  flags_out;

    mqtt_connect_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .field_id       (field_id),
        .data_byte      (data_byte),
        .field_end      (field_end),
        .done_res       (done_res),
        .malformed      (malformed),
        .return_code    (return_code),
        .assign_id      (assign_id),
        .keep_alive_out (keep_alive_out),
        .level_out      (level_out),
        .flags_out      (flags_out)
    );

    // parser state as predicted
    logic [7:0]  want_level = RESET_EXPECTED_LEVEL;
    logic [15:0] id_len_max = RESET_MAX_ID_LEN;
    field_t      pos;
    logic [7:0]  hi_byte;
    logic [15:0] remaining;
    logic        in_low;
    logic [7:0]  flags_seen;
    logic [7:0]  level_seen;
    logic [15:0] keepalive_seen;
    logic [15:0] id_len_seen;
    logic        id_has_bad;
    mal_t        err_code;

    parsed_byte_t expected_bytes[$];
    logic [7:0]   pkt[$];

    int cycle_count = 0;
    int error_count = 0;
    int checked_count = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int noise_sent = 0;
    int in_stalls = 0;
    int settings_run = 0;
    int burst_left = 0;
    bit tx_bursty = 1'b0;
    bit hold_req = 1'b0;
    logic hold_on = 1'b0;
    rx_mode_t rx_mode = RX_ALWAYS;
    logic [31:0] stall_pat = '1;
    logic [4:0]  pat_pos = 5'd0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d requests outstanding", expected_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver: own stall pattern, sometimes long runs of ready
    always @(posedge clk)
    begin
        if (hold_on)
            out_ready <= 1'b0;
        else if (rx_mode == RX_ALWAYS)
            out_ready <= 1'b1;
        else
            out_ready <= stall_pat[pat_pos];
        pat_pos <= pat_pos + 5'd1;
        if (pat_pos == 5'd31)
            stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h want %0h on result %0d",
                                   name, got, want, checked_count));
    endtask

    always @(posedge clk)
    begin : check_results
        parsed_byte_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_error("result with no request outstanding");
            end
            else
            begin
                want = expected_bytes.pop_front();
                check_field("field_id", 16'(field_id), 16'(want.field_id));
                check_field("data_byte", 16'(data_byte), 16'(want.data_byte));
                check_field("field_end", 16'(field_end), 16'(want.field_end));
                check_field("done_res", 16'(done_res), 16'(want.done));
                check_field("malformed", 16'(malformed), 16'(want.mal));
                check_field("return_code", 16'(return_code), 16'(want.rc));
                check_field("assign_id", 16'(assign_id), 16'(want.assign_id));
                check_field("keep_alive_out", keep_alive_out, want.ka);
                check_field("level_out", 16'(level_out), 16'(want.lvl));
                check_field("flags_out", 16'(flags_out), 16'(want.flg));
            end
            checked_count++;
        end
    end

    task automatic restart_packet();
        pos = FLD_NAME_LEN;
        hi_byte = 8'd0;
        remaining = 16'd0;
        in_low = 1'b0;
        flags_seen = 8'd0;
        level_seen = 8'd0;
        keepalive_seen = 16'd0;
        id_len_seen = 16'd0;
        id_has_bad = 1'b0;
        err_code = MAL_NONE;
    endtask

    function automatic logic is_length_field(input field_t f);
        return f == FLD_NAME_LEN || f == FLD_KEEPALIVE || f == FLD_ID_LEN ||
               f == FLD_WTOPIC_LEN || f == FLD_WMSG_LEN || f == FLD_USER_LEN ||
               f == FLD_PASS_LEN;
    endfunction

    function automatic logic id_char_ok(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    // which field comes after data field f, given the flags received
    function automatic field_t after_field(input field_t f, input logic [7:0] fl);
        if (f == FLD_NAME) return FLD_LEVEL;
        if (f == FLD_ID && fl[FLAG_WILL]) return FLD_WTOPIC_LEN;
        if (f == FLD_WTOPIC) return FLD_WMSG_LEN;
        if (f <= FLD_WMSG && fl[FLAG_USER]) return FLD_USER_LEN;
        if (f <= FLD_USER && fl[FLAG_PASS]) return FLD_PASS_LEN;
        return FLD_DISCARD;
    endfunction

    function automatic mal_t flags_fault(input logic [7:0] fl);
        if (fl[FLAG_RESERVED]) return MAL_RESERVED;
        if (!fl[FLAG_WILL] && fl[5:3] != 3'd0) return MAL_WILL_RULE;
        if (fl[4:3] == 2'b11) return MAL_QOS3;
        return MAL_NONE;
    endfunction

    task automatic parse_step(input logic [7:0] b, input logic l, output parsed_byte_t r);
        field_t tag;
        logic [15:0] v;
        mal_t fault;
        tag = pos;
        r = '0;
        r.field_id = tag;
        r.data_byte = b;
        if (tag == FLD_DISCARD)
        begin
            if (err_code == MAL_NONE) err_code = MAL_LENGTH;
        end
        else if (tag == FLD_LEVEL)
        begin
            level_seen = b;
            r.field_end = 1'b1;
            pos = FLD_FLAGS;
        end
        else if (tag == FLD_FLAGS)
        begin
            flags_seen = b;
            r.field_end = 1'b1;
            fault = flags_fault(b);
            if (fault != MAL_NONE)
            begin
                err_code = fault;
                pos = FLD_DISCARD;
            end
            else
            begin
                pos = FLD_KEEPALIVE;
            end
        end
        else if (is_length_field(tag))
        begin
            if (!in_low)
            begin
                hi_byte = b;
                in_low = 1'b1;
            end
            else
            begin
                v = {hi_byte, b};
                in_low = 1'b0;
                r.field_end = 1'b1;
                if (tag == FLD_KEEPALIVE)
                begin
                    keepalive_seen = v;
                    pos = FLD_ID_LEN;
                end
                else
                begin
                    remaining = v;
                    if (tag == FLD_ID_LEN) id_len_seen = v;
                    // a zero length skips the data field entirely
                    pos = (v == 16'd0) ? after_field(field_t'(tag + 4'd1), flags_seen)
                                       : field_t'(tag + 4'd1);
                end
            end
        end
        else
        begin
            if (tag == FLD_ID && !id_char_ok(b)) id_has_bad = 1'b1;
            if (remaining > 16'd0) remaining--;
            if (remaining == 16'd0)
            begin
                r.field_end = 1'b1;
                pos = after_field(tag, flags_seen);
            end
        end

        if (l)
        begin
            if (pos != FLD_DISCARD && err_code == MAL_NONE) err_code = MAL_LENGTH;
            r.done = 1'b1;
            r.mal = err_code;
            r.ka = keepalive_seen;
            r.lvl = level_seen;
            r.flg = flags_seen;
            if (err_code == MAL_NONE)
            begin
                if (level_seen != want_level)
                    r.rc = RC_BAD_LEVEL;
                else if (id_len_seen > id_len_max || id_has_bad)
                    r.rc = RC_ID_REJECT;
                else if (id_len_seen == 16'd0 && !flags_seen[FLAG_CLEAN])
                    r.rc = RC_ID_REJECT;
                else
                begin
                    r.assign_id = (id_len_seen == 16'd0);
                    if (flags_seen[FLAG_PASS] && !flags_seen[FLAG_USER])
                        r.rc = RC_BAD_CREDS;
                end
            end
            restart_packet();
        end
    endtask

    // one request; returns at the edge that took it, or after the burst gap
    task automatic send_byte(input logic [7:0] b, input logic l);
        parsed_byte_t r;
        in_valid <= 1'b1;
        rx_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready)
        begin
            in_stalls++;
            @(posedge clk);
        end
        parse_step(b, l, r);
        expected_bytes.push_back(r);
        bytes_sent++;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EXPECTED_LEVEL)
            want_level = val[7:0];
        else
            id_len_max = val;
        @(posedge clk);
    endtask

    function automatic logic [7:0] id_char();
        int n;
        n = $urandom_range(0, 61);
        if (n < 10) return 8'("0" + n);
        if (n < 36) return 8'("A" + n - 10);
        return 8'("a" + n - 36);
    endfunction

    task automatic push_field(input int len, input bit id_field, input bit spoil);
        int k;
        int bad_at;
        bad_at = (spoil && len > 0) ? $urandom_range(0, len - 1) : -1;
        pkt.push_back(8'(len >> 8));
        pkt.push_back(8'(len));
        for (k = 0; k < len; k++)
            pkt.push_back((id_field && k != bad_at) ? id_char() : 8'($urandom));
    endtask

    // connect with random content, mostly well formed, now and then with random flags, cut short or overrun
    task automatic send_connect();
        logic [7:0] lvl;
        logic [7:0] flg;
        int id_len;
        int k;
        pkt.delete();
        if ($urandom_range(0, 3) != 0)
        begin
            pkt.push_back(8'h00);
            pkt.push_back(8'h04);
            pkt.push_back("M");
            pkt.push_back("Q");
            pkt.push_back("T");
            pkt.push_back("T");
        end
        else
        begin
            push_field($urandom_range(0, 3), 1'b0, 1'b0);
        end
        lvl = ($urandom_range(0, 99) < 85) ? want_level : 8'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            flg = 8'($urandom);
        end
        else
        begin
            flg = 8'd0;
            flg[FLAG_CLEAN] = 1'($urandom);
            flg[FLAG_WILL] = 1'($urandom);
            if (flg[FLAG_WILL])
            begin
                flg[4:3] = 2'($urandom_range(0, 2));
                flg[FLAG_RETAIN] = 1'($urandom);
            end
            flg[FLAG_USER] = 1'($urandom);
            flg[FLAG_PASS] = 1'($urandom);
        end
        pkt.push_back(lvl);
        pkt.push_back(flg);
        case ($urandom_range(0, 3))
            0: begin pkt.push_back(8'h00); pkt.push_back(8'h00); end
            1: begin pkt.push_back(8'hff); pkt.push_back(8'hff); end
            default: begin pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom)); end
        endcase
        if ($urandom_range(0, 9) == 0)
            id_len = (int'(id_len_max) + $urandom_range(0, 2) > 40) ? 40
                     : int'(id_len_max) + $urandom_range(0, 2);
        else
            id_len = $urandom_range(0, 8);
        push_field(id_len, 1'b1, $urandom_range(0, 9) == 0);
        if (flg[FLAG_WILL])
        begin
            push_field($urandom_range(0, 5), 1'b0, 1'b0);
            push_field($urandom_range(0, 5), 1'b0, 1'b0);
        end
        if (flg[FLAG_USER]) push_field($urandom_range(0, 5), 1'b0, 1'b0);
        if (flg[FLAG_PASS]) push_field($urandom_range(0, 5), 1'b0, 1'b0);
        case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
            1: repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            default: ;
        endcase
        for (k = 0; k < pkt.size(); k++)
            send_byte(pkt[k], k == pkt.size() - 1);
        packets_sent++;
    endtask

    task automatic test_directed();
        // truncated after one byte
        send_byte(8'h00, 1'b1);
        // bad flags: reserved bit, will rule broken, will qos 3
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h04, 1'b0); send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h04, 1'b0); send_byte(8'h20, 1'b1);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h04, 1'b0); send_byte(8'h1c, 1'b1);
        // empty name and empty id with clean session, then the same with zero keep alive and one byte of overrun
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h04, 1'b0);
        send_byte(8'h02, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h04, 1'b0);
        send_byte(8'h02, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hab, 1'b1);
        wait_idle();
    endtask

    task automatic test_connect_stream(input int n);
        int target;
        target = bytes_sent + n;
        tx_bursty = 1'b1;
        rx_mode = RX_PATTERN;
        while (bytes_sent < target) send_connect();
        wait_idle();
    endtask

    task automatic test_noise(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_byte(8'($urandom), k == n - 1 || $urandom_range(0, 7) == 0);
        noise_sent += n;
        wait_idle();
    endtask

    task automatic test_backpressure();
        int target;
        tx_bursty = 1'b0;
        hold_req = 1'b1;
        target = bytes_sent + 60;
        while (bytes_sent < target) send_connect();
        wait_idle();
        tx_bursty = 1'b1;
    endtask

    task automatic run_setting(input logic [7:0] lvl, input logic [15:0] max_len,
                               input int n);
        int target;
        wait_idle();
        write_cfg(CFG_EXPECTED_LEVEL, {8'd0, lvl});
        write_cfg(CFG_MAX_ID_LEN, max_len);
        settings_run++;
        target = bytes_sent + n;
        while (bytes_sent < target) send_connect();
        wait_idle();
    endtask

    task automatic test_config_sweep();
        run_setting(8'd0, 16'd0, 200);
        run_setting(8'd255, 16'hffff, 200);
        run_setting(8'd4, 16'd5, 200);
        run_setting(8'($urandom), 16'($urandom_range(0, 40)), 200);
        run_setting(RESET_EXPECTED_LEVEL, RESET_MAX_ID_LEN, 100);
    endtask

    initial
    begin
        restart_packet();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_connect_stream(600);
        test_noise(200);
        test_backpressure();
        test_config_sweep();

        wait_idle();
        if (expected_bytes.size() != 0)
            report_error("requests left without a result");
        $display("run covered %0d connect packets and %0d noise bytes, %0d bytes checked",
                 packets_sent, noise_sent, checked_count);
        $display("%0d register settings, %0d input stall cycles, %0d mismatches",
                 settings_run + 1, in_stalls, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
